// ===== design/mtq_pkg.sv =====
// Shared constants, codes and types for the max tracking queue.
package mtq_pkg;

  // Stack store depth and derived widths
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PTR_W  = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 11;

  localparam logic signed [DATA_W-1:0] MIN_VALUE = {1'b1, {(DATA_W-1){1'b0}}};

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ENQ   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef logic signed [DATA_W-1:0] word_t;

  // One stack entry: the item and the stack maximum below it
  typedef struct packed {
    word_t value;
    word_t prior_max;
  } mtq_entry_t;

endpackage

// ===== design/mtq_if.sv =====
// Handshake channel interfaces: request, response and configuration.
interface mtq_req_if;
  import mtq_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  word_t            value;
  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface mtq_rsp_if;
  import mtq_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  word_t             dequeued;
  word_t             current_max;
  logic              is_empty;
  logic [OCC_W-1:0]  occupancy;
  modport source (output valid, status, dequeued, current_max, is_empty, occupancy,
                  input ready);
  modport sink   (input valid, status, dequeued, current_max, is_empty, occupancy,
                  output ready);
endinterface

interface mtq_cfg_if;
  import mtq_pkg::*;
  logic             valid;
  logic             ready;
  logic [OCC_W-1:0] capacity;
  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

// ===== design/max_tracking_queue_unit.sv =====
// Max tracking queue: FIFO of signed words built from two stacks, reports its maximum.
//
// Channels: req carries one word (action, value); rsp returns one word per
// request (status, dequeued, current_max, is_empty, occupancy); cfg writes the
// capacity register (always ready, write only while the queue is idle).
// Actions: enqueue, dequeue, query. Full enqueues and empty dequeues are
// reported by status and change nothing.
// Steps after accept: enqueue, query and refused ops pass EXEC and FIN;
// a dequeue with the output stack non-empty passes EXEC, PRD, POP and FIN;
// with the output stack empty, EXEC is followed by one XRD/XWR pair per word
// of the input stack, since each moved word takes one registered read of the
// input store and one write of the output store, and then by PRD, POP and FIN.
// Throughput: one request at a time; req.ready is high only while idle. A
// finished response waits in its own register, so a new request is taken while
// the receiver stalls; that request then holds in its final step.
// Reset (rst, synchronous): queue empty, capacity 1024, maxima at the minimum
// integer. Stack stores are not cleared; entries are read only after written.
module max_tracking_queue_unit (
  input logic        clk,
  input logic        rst,
  mtq_cfg_if.sink    cfg,
  mtq_req_if.sink    req,
  mtq_rsp_if.source  rsp
);
  import mtq_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;  // decode, enqueue push
  localparam logic [2:0] S_XRD  = 3'd2;  // transfer: read input stack top
  localparam logic [2:0] S_XWR  = 3'd3;  // transfer: push onto output stack
  localparam logic [2:0] S_PRD  = 3'd4;  // dequeue: read output stack top
  localparam logic [2:0] S_POP  = 3'd5;  // dequeue: take value, restore max
  localparam logic [2:0] S_FIN  = 3'd6;  // load response register

  logic [2:0]       state;
  logic [OCC_W-1:0] capacity;
  logic [OCC_W-1:0] count;
  logic [PTR_W-1:0] in_top;
  logic [PTR_W-1:0] out_top;
  word_t            in_max;
  word_t            out_max;

  // Latched request and work results
  logic [ACT_W-1:0]  act;
  word_t             x_val;
  logic [STAT_W-1:0] status;
  word_t             deq_val;

  // Response register
  logic              res_valid;
  logic [STAT_W-1:0] res_status;
  word_t             res_deq;
  word_t             res_max;
  logic              res_empty;
  logic [OCC_W-1:0]  res_occ;

  // Stack stores, one write and one registered read port each
  mtq_entry_t in_mem  [DEPTH];
  mtq_entry_t out_mem [DEPTH];
  mtq_entry_t in_rd;
  mtq_entry_t out_rd;

  logic             in_wr_en;
  logic             in_rd_en;
  logic             out_wr_en;
  logic             out_rd_en;
  mtq_entry_t       in_wdata;
  mtq_entry_t       out_wdata;
  logic [PTR_W-1:0] in_top_dec;
  logic [PTR_W-1:0] out_top_dec;
  logic             full;
  logic             res_load;

  assign in_top_dec  = in_top - PTR_W'(1);
  assign out_top_dec = out_top - PTR_W'(1);

  // Capacity above the store depth acts as the depth
  assign full = (count >= capacity) || (count >= OCC_W'(DEPTH));

  assign in_wr_en  = (state == S_EXEC) && (act == ACT_ENQ) && !full;
  assign in_rd_en  = (state == S_XRD);
  assign out_wr_en = (state == S_XWR);
  assign out_rd_en = (state == S_PRD);

  // Each entry keeps the stack max below it, restored on an output stack pop
  assign in_wdata  = '{value: x_val, prior_max: in_max};
  assign out_wdata = '{value: in_rd.value, prior_max: out_max};

  assign res_load = (state == S_FIN) && (!res_valid || rsp.ready);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid       = res_valid;
  assign rsp.status      = res_status;
  assign rsp.dequeued    = res_deq;
  assign rsp.current_max = res_max;
  assign rsp.is_empty    = res_empty;
  assign rsp.occupancy   = res_occ;

  always_ff @(posedge clk) begin
    if (in_wr_en) begin
      in_mem[in_top[ADDR_W-1:0]] <= in_wdata;
    end
    if (in_rd_en) begin
      in_rd <= in_mem[in_top_dec[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (out_wr_en) begin
      out_mem[out_top[ADDR_W-1:0]] <= out_wdata;
    end
    if (out_rd_en) begin
      out_rd <= out_mem[out_top_dec[ADDR_W-1:0]];
    end
  end

  // Control and stack state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= OCC_W'(DEPTH);
      count     <= '0;
      in_top    <= '0;
      out_top   <= '0;
      in_max    <= MIN_VALUE;
      out_max   <= MIN_VALUE;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.capacity;
      end
      // a taken response clears unless the next one loads on the same edge
      if (rsp.valid && rsp.ready && !res_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (act)
            ACT_ENQ: begin
              if (!full) begin
                in_top <= in_top + PTR_W'(1);
                count  <= count + OCC_W'(1);
                if (x_val > in_max) begin
                  in_max <= x_val;
                end
              end
              state <= S_FIN;
            end
            ACT_DEQ: begin
              if (count == '0) begin
                state <= S_FIN;
              end else if (out_top == '0) begin
                state <= S_XRD;  // non-empty queue: input stack holds words
              end else begin
                state <= S_PRD;
              end
            end
            default: begin
              state <= S_FIN;
            end
          endcase
        end
        S_XRD: begin
          in_top <= in_top_dec;
          state  <= S_XWR;
        end
        S_XWR: begin
          out_top <= out_top + PTR_W'(1);
          if (in_rd.value > out_max) begin
            out_max <= in_rd.value;
          end
          if (in_top == '0) begin
            in_max <= MIN_VALUE;
            state  <= S_PRD;
          end else begin
            state <= S_XRD;
          end
        end
        S_PRD: begin
          out_top <= out_top_dec;
          state   <= S_POP;
        end
        S_POP: begin
          out_max <= out_rd.prior_max;
          count   <= count - OCC_W'(1);
          state   <= S_FIN;
        end
        S_FIN: begin
          if (res_load) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      act   <= req.action;
      x_val <= req.value;
    end
    if (state == S_EXEC) begin
      deq_val <= '0;
      if ((act == ACT_ENQ) && full) begin
        status <= ST_FULL;
      end else if ((act == ACT_DEQ) && (count == '0)) begin
        status <= ST_EMPTY;
      end else begin
        status <= ST_DONE;
      end
    end
    if (state == S_POP) begin
      deq_val <= out_rd.value;
    end
    if (res_load) begin
      res_status <= status;
      res_deq    <= deq_val;
      res_empty  <= (count == '0);
      res_occ    <= count;
      if (count == '0) begin
        res_max <= MIN_VALUE;
      end else if (in_max > out_max) begin
        res_max <= in_max;
      end else begin
        res_max <= out_max;
      end
    end
  end

endmodule

// ===== design/mtq_checker.sv =====
// Port-level checks on the max tracking queue response channel, bound to the top.
module mtq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [mtq_pkg::STAT_W-1:0] rsp_status,
  input mtq_pkg::word_t             rsp_dequeued,
  input mtq_pkg::word_t             rsp_current_max,
  input logic                       rsp_is_empty,
  input logic [mtq_pkg::OCC_W-1:0]  rsp_occupancy
);
  import mtq_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_current_max)
      && $stable(rsp_occupancy) && $stable(rsp_dequeued))
    else $error("response changed while stalled");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_is_empty == (rsp_occupancy == '0))
    else $error("empty flag disagrees with occupancy");

  a_empty_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_is_empty |-> rsp_current_max == MIN_VALUE)
    else $error("empty queue reports a maximum");

  a_empty_deq: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_is_empty && (rsp_dequeued == '0))
    else $error("empty dequeue reported with data");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_occupancy <= OCC_W'(DEPTH))
    else $error("occupancy beyond store depth");

endmodule

bind max_tracking_queue_unit mtq_checker u_mtq_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_dequeued    (rsp.dequeued),
  .rsp_current_max (rsp.current_max),
  .rsp_is_empty    (rsp.is_empty),
  .rsp_occupancy   (rsp.occupancy)
);
